FILE: rtl/core/cfa_pkg.sv
`timescale 1ns / 1ps
package cfa_pkg;

	localparam int CfgW   = 31;
	localparam int CfgIdxW = 3;
	localparam int PosW   = 32;
	localparam int SumW   = 48;

	// Register indexes
	localparam logic [CfgIdxW-1:0] REG_CENTRAL   = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_REP_FACT  = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_REP_RANGE = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_ADH_RANGE = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_ADH_FACT  = 3'd4;
	localparam logic [CfgIdxW-1:0] REG_TIME_STEP = 3'd5;

	// Register reset values
	localparam logic [CfgW-1:0] RST_CENTRAL   = 31'd65536;
	localparam logic [CfgW-1:0] RST_REP_FACT  = 31'd65536;
	localparam logic [CfgW-1:0] RST_REP_RANGE = 31'd131072;
	localparam logic [CfgW-1:0] RST_ADH_RANGE = 31'd65536;
	localparam logic [CfgW-1:0] RST_ADH_FACT  = 31'd65536;
	localparam logic [CfgW-1:0] RST_TIME_STEP = 31'd6554;

	localparam logic OP_START    = 1'b0;
	localparam logic OP_NEIGHBOR = 1'b1;

	// Magnitude of a signed 32-bit value
	function automatic logic [31:0] mag32(input logic signed [31:0] v);
		mag32 = v[31] ? (32'd0 - 32'(v)) : 32'(v);
	endfunction

	// Clamp a 49-bit sum to the 48-bit signed range
	function automatic logic signed [47:0] sat48(input logic signed [48:0] v);
		if (v[48] != v[47])
			sat48 = v[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
		else
			sat48 = v[47:0];
	endfunction

endpackage

FILE: rtl/core/cfa_in_if.sv
`timescale 1ns / 1ps
interface cfa_in_if;
	logic               valid;
	logic               ready;
	logic               op;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic signed [31:0] pos_z;
	logic signed [31:0] added_x;
	logic signed [31:0] added_y;
	logic signed [31:0] added_z;
	logic               last;

	modport source (output valid, op, pos_x, pos_y, pos_z, added_x, added_y, added_z, last,
		input ready);
	modport sink (input valid, op, pos_x, pos_y, pos_z, added_x, added_y, added_z, last,
		output ready);
endinterface

FILE: rtl/core/cfa_out_if.sv
`timescale 1ns / 1ps
interface cfa_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] force_x;
	logic signed [31:0] force_y;
	logic signed [31:0] force_z;

	modport source (output valid, force_x, force_y, force_z, input ready);
	modport sink (input valid, force_x, force_y, force_z, output ready);
endinterface

FILE: rtl/core/cfa_cfg_if.sv
`timescale 1ns / 1ps
interface cfa_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [30:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/core/cfa_sqrt.sv
`timescale 1ns / 1ps
module cfa_sqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] radicand,
	output logic        done,
	output logic [31:0] root
);
	logic [63:0] rad_q;
	logic [33:0] rem_q;
	logic [31:0] root_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [35:0] rem_sh;
	logic [35:0] trial;
	logic        fits;

	// One result bit per step: bring down two radicand bits, try root*4+1
	assign rem_sh = {rem_q, rad_q[63:62]};
	assign trial  = {2'b00, root_q, 2'b01};
	assign fits   = rem_sh >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[61:0], 2'b00};
			rem_q  <= fits ? 34'(rem_sh - trial) : rem_sh[33:0];
			root_q <= {root_q[30:0], fits};
		end
	end

	assign done = done_q;
	assign root = root_q;
endmodule

FILE: rtl/core/cfa_div.sv
`timescale 1ns / 1ps
module cfa_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] dividend,
	input  logic [31:0] divisor,
	output logic        done,
	output logic [31:0] quotient
);
	// Callers guarantee the quotient fits 32 bits: upper half below divisor
	logic [31:0] rem_q;
	logic [31:0] low_q;
	logic [31:0] div_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [32:0] rem_sh;
	logic        fits;

	assign rem_sh = {rem_q, low_q[31]};
	assign fits   = rem_sh >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Shift in one dividend bit a step; low register collects quotient bits
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend[63:32];
			low_q <= dividend[31:0];
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? 32'(rem_sh - {1'b0, div_q}) : rem_sh[31:0];
			low_q <= {low_q[30:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = low_q;
endmodule

FILE: rtl/core/cell_force_accumulator.sv
`timescale 1ns / 1ps
// Force accumulator for one cell, signed Q16.16. A start beat stores the cell
// position and seeds the central pull; neighbor beats add repulsion and
// adhesion; a beat with last set yields the total times the time step. Input
// beats share one multiplier, a 32-step square root and a 32-step divider
// under a sequencer; a beat that closes the cell waits while the previous
// result has not been taken. The input is not ready while a beat is in work;
// a finished result waits in the output register while the next beat runs.
module cell_force_accumulator
	import cfa_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	cfa_in_if.sink    din,
	cfa_out_if.source dout,
	cfa_cfg_if.sink   cfg
);
	localparam logic [4:0] ST_IDLE  = 5'd0;
	localparam logic [4:0] ST_SQ    = 5'd1;
	localparam logic [4:0] ST_SQA   = 5'd2;
	localparam logic [4:0] ST_SQRT  = 5'd3;
	localparam logic [4:0] ST_SQRTW = 5'd4;
	localparam logic [4:0] ST_BR    = 5'd5;
	localparam logic [4:0] ST_CMUL  = 5'd6;
	localparam logic [4:0] ST_CDIV  = 5'd7;
	localparam logic [4:0] ST_CDIVW = 5'd8;
	localparam logic [4:0] ST_RMUL  = 5'd9;
	localparam logic [4:0] ST_RDIV  = 5'd10;
	localparam logic [4:0] ST_RDIVW = 5'd11;
	localparam logic [4:0] ST_MMUL  = 5'd12;
	localparam logic [4:0] ST_MDIV  = 5'd13;
	localparam logic [4:0] ST_MDIVW = 5'd14;
	localparam logic [4:0] ST_AMUL  = 5'd15;
	localparam logic [4:0] ST_AACC  = 5'd16;
	localparam logic [4:0] ST_FIN   = 5'd17;
	localparam logic [4:0] ST_TOT   = 5'd18;
	localparam logic [4:0] ST_OM1   = 5'd19;
	localparam logic [4:0] ST_OM2   = 5'd20;
	localparam logic [4:0] ST_OM3   = 5'd21;
	localparam logic [4:0] ST_OUT   = 5'd22;

	logic [CfgW-1:0] cf_q, rf_q, rr_q, ar_q, af_q, ts_q;

	logic [4:0]               state_q;
	logic [1:0]               idx_q;
	logic                     op_q, last_q;
	logic signed [PosW-1:0]   self_q [3];
	logic signed [PosW-1:0]   vec_q  [3];
	logic signed [PosW-1:0]   a_q    [3];
	logic signed [SumW-1:0]   fs_q   [3];
	logic signed [SumW-1:0]   cs_q   [3];
	logic signed [PosW-1:0]   res_q  [3];
	logic [63:0]              sum_q, prod_q, hi_q;
	logic [31:0]              dist_q;
	logic [30:0]              t_q;
	logic [48:0]              tmag_q;
	logic                     tneg_q;
	logic                     ov_q;

	logic                     in_acc;
	logic                     out_load;
	logic signed [PosW-1:0]   pin   [3];
	logic signed [PosW-1:0]   vin   [3];
	logic [32:0]              mul_a;
	logic [31:0]              mul_b;
	logic [64:0]              mul_full;
	logic [63:0]              mul_p;
	logic                     sq_start, sq_done, dv_start, dv_done;
	logic [31:0]              sq_root, dv_quot, dv_divisor;
	logic [31:0]              vmag, amag;
	logic                     rep_on, adh_on;
	logic signed [48:0]       tot;
	logic [63:0]              rsum;
	logic signed [48:0]       fs_add, cs_add;

	assign in_acc    = din.valid && din.ready;
	assign din.ready = (state_q == ST_IDLE);
	assign cfg.ready = 1'b1;
	assign out_load  = (state_q == ST_OUT) && (!ov_q || dout.ready);

	assign pin[0] = din.pos_x;
	assign pin[1] = din.pos_y;
	assign pin[2] = din.pos_z;

	// Clamp self minus neighbor to 32 bits; start beats take the position itself
	always_comb begin
		logic signed [32:0] diff;
		for (int i = 0; i < 3; i++) begin
			diff = {self_q[i][31], self_q[i]} - {pin[i][31], pin[i]};
			if (din.op == OP_START)
				vin[i] = pin[i];
			else if (diff[32] != diff[31])
				vin[i] = diff[32] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
			else
				vin[i] = diff[31:0];
		end
	end

	assign vmag   = mag32(vec_q[idx_q]);
	assign amag   = mag32(a_q[idx_q]);
	assign rep_on = (dist_q != 32'd0) && (dist_q < {1'b0, rr_q});
	assign adh_on = dist_q < {1'b0, ar_q};

	// Shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_SQ: begin
				mul_a = {1'b0, vmag};
				mul_b = vmag;
			end
			ST_CMUL: begin
				mul_a = {1'b0, vmag};
				mul_b = {1'b0, cf_q};
			end
			ST_RMUL: begin
				mul_a = {2'b00, rf_q};
				mul_b = 32'({1'b0, rr_q} - dist_q);
			end
			ST_MMUL: begin
				mul_a = {1'b0, vmag};
				mul_b = {1'b0, t_q};
			end
			ST_AMUL: begin
				mul_a = {1'b0, amag};
				mul_b = {1'b0, af_q};
			end
			ST_OM1: begin
				mul_a = tmag_q[48:16];
				mul_b = {1'b0, ts_q};
			end
			ST_OM2: begin
				mul_a = {17'd0, tmag_q[15:0]};
				mul_b = {1'b0, ts_q};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end
	assign mul_full = mul_a * mul_b;
	assign mul_p    = mul_full[63:0];

	assign sq_start = (state_q == ST_SQRT);
	assign dv_start = (state_q == ST_CDIV) || (state_q == ST_RDIV) || (state_q == ST_MDIV);
	assign dv_divisor = (state_q == ST_RDIV) ? {1'b0, rr_q} : dist_q;

	cfa_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sq_start),
		.radicand (sum_q),
		.done     (sq_done),
		.root     (sq_root)
	);

	cfa_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (dv_start),
		.dividend (prod_q),
		.divisor  (dv_divisor),
		.done     (dv_done),
		.quotient (dv_quot)
	);

	assign tot  = {fs_q[idx_q][47], fs_q[idx_q]} + {cs_q[idx_q][47], cs_q[idx_q]};
	assign rsum = hi_q + {16'd0, prod_q[63:16]};
	assign fs_add = vec_q[idx_q][31] ? -$signed({18'd0, dv_quot[30:0]})
		: $signed({18'd0, dv_quot[30:0]});
	assign cs_add = a_q[idx_q][31] ? -$signed({1'b0, prod_q[63:16]})
		: $signed({1'b0, prod_q[63:16]});

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cf_q <= RST_CENTRAL;
			rf_q <= RST_REP_FACT;
			rr_q <= RST_REP_RANGE;
			ar_q <= RST_ADH_RANGE;
			af_q <= RST_ADH_FACT;
			ts_q <= RST_TIME_STEP;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				REG_CENTRAL:   cf_q <= cfg.data;
				REG_REP_FACT:  rf_q <= cfg.data;
				REG_REP_RANGE: rr_q <= cfg.data;
				REG_ADH_RANGE: ar_q <= cfg.data;
				REG_ADH_FACT:  af_q <= cfg.data;
				REG_TIME_STEP: ts_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// Sequencer and cell state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
			ov_q    <= 1'b0;
			op_q    <= 1'b0;
			last_q  <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				self_q[i] <= '0;
				fs_q[i]   <= '0;
				cs_q[i]   <= '0;
			end
		end else begin
			if (out_load)
				ov_q <= 1'b1;
			else if (dout.valid && dout.ready)
				ov_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						op_q   <= din.op;
						last_q <= din.last;
						idx_q  <= '0;
						state_q <= ST_SQ;
						if (din.op == OP_START) begin
							for (int i = 0; i < 3; i++) begin
								self_q[i] <= pin[i];
								fs_q[i]   <= '0;
								cs_q[i]   <= '0;
							end
						end
					end
				end
				ST_SQ: state_q <= ST_SQA;
				ST_SQA: begin
					idx_q   <= idx_q + 2'd1;
					state_q <= (idx_q == 2'd2) ? ST_SQRT : ST_SQ;
				end
				ST_SQRT: state_q <= ST_SQRTW;
				ST_SQRTW: if (sq_done) state_q <= ST_BR;
				ST_BR: begin
					idx_q <= '0;
					if (op_q == OP_START)
						state_q <= (dist_q != 32'd0) ? ST_CMUL : ST_FIN;
					else if (rep_on)
						state_q <= ST_RMUL;
					else
						state_q <= adh_on ? ST_AMUL : ST_FIN;
				end
				ST_CMUL: state_q <= ST_CDIV;
				ST_CDIV: state_q <= ST_CDIVW;
				ST_CDIVW: begin
					if (dv_done) begin
						fs_q[idx_q] <= (vec_q[idx_q] > 0) ? -$signed({17'd0, dv_quot[30:0]})
							: $signed({17'd0, dv_quot[30:0]});
						idx_q   <= idx_q + 2'd1;
						state_q <= (idx_q == 2'd2) ? ST_FIN : ST_CMUL;
					end
				end
				ST_RMUL: state_q <= ST_RDIV;
				ST_RDIV: state_q <= ST_RDIVW;
				ST_RDIVW: if (dv_done) state_q <= ST_MMUL;
				ST_MMUL: state_q <= ST_MDIV;
				ST_MDIV: state_q <= ST_MDIVW;
				ST_MDIVW: begin
					if (dv_done) begin
						fs_q[idx_q] <= sat48({fs_q[idx_q][47], fs_q[idx_q]} + fs_add);
						if (idx_q == 2'd2) begin
							idx_q   <= '0;
							state_q <= adh_on ? ST_AMUL : ST_FIN;
						end else begin
							idx_q   <= idx_q + 2'd1;
							state_q <= ST_MMUL;
						end
					end
				end
				ST_AMUL: state_q <= ST_AACC;
				ST_AACC: begin
					cs_q[idx_q] <= sat48({cs_q[idx_q][47], cs_q[idx_q]} + cs_add);
					idx_q   <= idx_q + 2'd1;
					state_q <= (idx_q == 2'd2) ? ST_FIN : ST_AMUL;
				end
				ST_FIN: begin
					idx_q   <= '0;
					state_q <= last_q ? ST_TOT : ST_IDLE;
				end
				ST_TOT: state_q <= ST_OM1;
				ST_OM1: state_q <= ST_OM2;
				ST_OM2: state_q <= ST_OM3;
				ST_OM3: begin
					idx_q   <= idx_q + 2'd1;
					state_q <= (idx_q == 2'd2) ? ST_OUT : ST_TOT;
				end
				ST_OUT: begin
					if (out_load)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					vec_q[0] <= vin[0];
					vec_q[1] <= vin[1];
					vec_q[2] <= vin[2];
					a_q[0]   <= din.added_x;
					a_q[1]   <= din.added_y;
					a_q[2]   <= din.added_z;
					sum_q    <= '0;
				end
			end
			ST_SQA: sum_q <= sum_q + prod_q;
			ST_SQRTW: if (sq_done) dist_q <= sq_root;
			ST_RDIVW: if (dv_done) t_q <= dv_quot[30:0];
			ST_TOT: begin
				tneg_q <= tot[48];
				tmag_q <= tot[48] ? 49'(-tot) : 49'(tot);
			end
			ST_OM2: hi_q <= prod_q;
			ST_OM3: begin
				if (tneg_q)
					res_q[idx_q] <= (rsum > 64'h8000_0000) ? {1'b1, 31'd0}
						: 32'(64'd0 - rsum);
				else
					res_q[idx_q] <= (rsum > 64'h7FFF_FFFF) ? {1'b0, {31{1'b1}}}
						: rsum[31:0];
			end
			default: ;
		endcase
		if (state_q == ST_SQ || state_q == ST_CMUL || state_q == ST_RMUL
			|| state_q == ST_MMUL || state_q == ST_AMUL || state_q == ST_OM1
			|| state_q == ST_OM2)
			prod_q <= mul_p;
	end

	// Hold the result beat until taken
	logic signed [PosW-1:0] fx_q, fy_q, fz_q;
	always_ff @(posedge clk) begin
		if (out_load) begin
			fx_q <= res_q[0];
			fy_q <= res_q[1];
			fz_q <= res_q[2];
		end
	end

	assign dout.valid   = ov_q;
	assign dout.force_x = fx_q;
	assign dout.force_y = fy_q;
	assign dout.force_z = fz_q;
endmodule
